// File: rtl/tjp_pkg.sv
package tjp_pkg;

  localparam int NW  = 10;
  localparam int NCW = 11;
  localparam int KW  = 3;

  localparam logic [NCW-1:0] NODE_COUNT_RST = 11'd1024;

  typedef enum logic [KW-1:0] {
    K_CLEAR = 3'd0,
    K_LOAD  = 3'd1,
    K_BUILD = 3'd2,
    K_JUMP  = 3'd3,
    K_LCA   = 3'd4,
    K_PATH  = 3'd5,
    K_DIST  = 3'd6,
    K_MED   = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTBUILT = 2'd1,
    ST_PASTEND  = 2'd2,
    ST_RANGE    = 2'd3
  } status_e;

  typedef enum logic [5:0] {
    S_CLR, S_IDLE, S_LRA, S_LWA, S_LRB, S_LWB,
    S_BCP_RD, S_BCP_WR, S_PRD, S_PCHK, S_PDO, S_PDO2, S_PEND,
    S_RCHK, S_RV, S_RQ, S_RJ1, S_RJ2, S_RWR,
    S_CRD, S_CJ, S_CST,
    S_MRA, S_MRB, S_MSW, S_MEQ, S_MRU, S_MRV, S_MCMP,
    S_QDM, S_QDM2, S_RET, S_DONE
  } state_e;

  typedef struct packed {
    logic [KW-1:0] kind;
    logic [NW-1:0] node_a;
    logic [NW-1:0] node_b;
    logic [NW-1:0] node_c;
    logic          is_root;
    logic [NW-1:0] steps;
  } req_t;

  typedef struct packed {
    logic [NW-1:0] node_out;
    logic [NW-1:0] distance;
    status_e       status;
  } rsp_t;

endpackage

// File: rtl/tjp_req_if.sv
interface tjp_req_if import tjp_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [KW-1:0] kind;
  logic [NW-1:0] node_a;
  logic [NW-1:0] node_b;
  logic [NW-1:0] node_c;
  logic          is_root;
  logic [NW-1:0] steps;

  modport source (output valid, kind, node_a, node_b, node_c, is_root, steps, input ready);
  modport sink   (input valid, kind, node_a, node_b, node_c, is_root, steps, output ready);
endinterface

// File: rtl/tjp_rsp_if.sv
interface tjp_rsp_if import tjp_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [NW-1:0] node_out;
  logic [NW-1:0] distance;
  logic [1:0]    status;

  modport source (output valid, node_out, distance, status, input ready);
  modport sink   (input valid, node_out, distance, status, output ready);
endinterface

// File: rtl/tjp_core.sv
module tjp_core import tjp_pkg::*; #(
  parameter int MAX_NODES = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  req_t           req_i,
  input  logic [NCW-1:0] n_i,
  input  logic           cfg_we_i,
  output logic           idle_o,
  output logic           done_o,
  output rsp_t           rsp_o
);

  localparam int AW = $clog2(MAX_NODES);
  localparam logic signed [NCW-1:0] WDEG_ONE = NCW'(1);

  logic [NW-1:0]         deg_mem  [MAX_NODES];
  logic [NW-1:0]         nx_mem   [MAX_NODES];
  logic signed [NCW-1:0] wdeg_mem [MAX_NODES];
  logic [NW-1:0]         wadj_mem [MAX_NODES];
  logic                  peel_mem [MAX_NODES];
  logic [NW-1:0]         par_mem  [MAX_NODES];
  logic [NW-1:0]         dep_mem  [MAX_NODES];
  logic [NW-1:0]         jmp_mem  [MAX_NODES];
  logic [NW-1:0]         ord_mem  [MAX_NODES-1];

  logic                  deg_we, wdeg_we, wadj_we, peel_we, par_we, dep_we, jmp_we, ord_we;
  logic [AW-1:0]         deg_wa, wdeg_wa, wadj_wa, peel_wa, par_wa, dep_wa, jmp_wa, ord_wa;
  logic [AW-1:0]         deg_ra, wdeg_ra, peel_ra, par_ra, dep_ra, jmp_ra, ord_ra;
  logic [NW-1:0]         deg_wd, nx_wd, wadj_wd, par_wd, dep_wd, jmp_wd, ord_wd;
  logic signed [NCW-1:0] wdeg_wd;
  logic                  peel_wd;
  logic [NW-1:0]         deg_rd, nx_rd, wadj_rd, par_rd, dep_rd, jmp_rd, ord_rd;
  logic signed [NCW-1:0] wdeg_rd;
  logic                  peel_rd;

  state_e                st_q, st_d;
  req_t                  r_q;
  rsp_t                  rsp_q;
  logic [NCW-1:0]        i_q, v_q, len_q;
  logic [NW-1:0]         q_q, root_q, u_q, w_q, ck_q, dv_q, jv_q, pv_q;
  logic [NW-1:0]         da_q, db_q, m_q, pu_q, ju_q, acc_q;
  logic [NW-1:0]         dq_q, j2_q, dj1_q, tadj_q;
  logic signed [NCW-1:0] tdeg_q;
  logic [AW-1:0]         clr_q;
  logic [1:0]            phase_q;
  logic                  built_q, clamp_q, inmeet_q, pend_q;

  logic                  a_bad, b_bad, c_bad, q_bad, peel_fail, len_ok;
  logic [NW-1:0]         kk, cdist, up;
  logic [NCW-1:0]        tot, kx;
  logic                  jump_ok;

  always_ff @(posedge clk_i) begin
    if (deg_we) begin
      deg_mem[deg_wa] <= deg_wd;
      nx_mem[deg_wa]  <= nx_wd;
    end
    if (wdeg_we) wdeg_mem[wdeg_wa] <= wdeg_wd;
    if (wadj_we) wadj_mem[wadj_wa] <= wadj_wd;
    if (peel_we) peel_mem[peel_wa] <= peel_wd;
    if (par_we)  par_mem[par_wa]   <= par_wd;
    if (dep_we)  dep_mem[dep_wa]   <= dep_wd;
    if (jmp_we)  jmp_mem[jmp_wa]   <= jmp_wd;
    if (ord_we)  ord_mem[ord_wa]   <= ord_wd;
    deg_rd  <= deg_mem[deg_ra];
    nx_rd   <= nx_mem[deg_ra];
    wdeg_rd <= wdeg_mem[wdeg_ra];
    wadj_rd <= wadj_mem[wdeg_ra];
    peel_rd <= peel_mem[peel_ra];
    par_rd  <= par_mem[par_ra];
    dep_rd  <= dep_mem[dep_ra];
    jmp_rd  <= jmp_mem[jmp_ra];
    ord_rd  <= ord_mem[ord_ra];
  end

  always_comb begin
    a_bad     = NCW'(req_i.node_a) >= n_i;
    b_bad     = NCW'(req_i.node_b) >= n_i;
    c_bad     = NCW'(req_i.node_c) >= n_i;
    q_bad     = NCW'(q_q) >= n_i;
    peel_fail = q_bad || (NCW'(q_q) == v_q) || peel_rd || (32'(len_q) >= MAX_NODES - 1);
    len_ok    = len_q == NCW'(n_i - 1'b1);
    kk        = (clamp_q && (dep_rd < ck_q)) ? dep_rd : ck_q;
    cdist     = dv_q - dep_rd;
    up        = da_q - dep_rd;
    tot       = NCW'(up) + NCW'(db_q) - NCW'(dep_rd);
    kx        = NCW'(r_q.steps);
    jump_ok   = (NCW'(dq_q) + NCW'(dep_rd)) == {dj1_q, 1'b0};
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_CLR: begin
        if (clr_q == AW'(MAX_NODES - 1)) st_d = pend_q ? S_DONE : S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          unique case (kind_e'(req_i.kind))
            K_CLEAR: st_d = S_CLR;
            K_LOAD: begin
              if (a_bad || (!req_i.is_root && b_bad) || req_i.is_root) st_d = S_DONE;
              else st_d = S_LRA;
            end
            K_BUILD: begin
              if (n_i == '0 || NCW'(root_q) >= n_i) st_d = S_DONE;
              else st_d = S_BCP_RD;
            end
            K_JUMP: begin
              if (!built_q || a_bad) st_d = S_DONE;
              else st_d = S_CRD;
            end
            K_MED: begin
              if (!built_q || a_bad || b_bad || c_bad) st_d = S_DONE;
              else st_d = S_MRA;
            end
            K_LCA, K_PATH, K_DIST: begin
              if (!built_q || a_bad || b_bad) st_d = S_DONE;
              else st_d = S_MRA;
            end
          endcase
        end
      end
      S_LRA:    st_d = S_LWA;
      S_LWA:    st_d = S_LRB;
      S_LRB:    st_d = S_LWB;
      S_LWB:    st_d = S_DONE;
      S_BCP_RD: st_d = S_BCP_WR;
      S_BCP_WR: st_d = (NCW'(i_q + 1'b1) == n_i) ? S_PRD : S_BCP_RD;
      S_PRD:    st_d = S_PCHK;
      S_PCHK: begin
        if (wdeg_rd == WDEG_ONE) st_d = S_PDO;
        else if (NCW'(i_q + 1'b1) == n_i) st_d = S_PEND;
        else st_d = S_PRD;
      end
      S_PDO:    st_d = peel_fail ? S_DONE : S_PDO2;
      S_PDO2:   st_d = S_PRD;
      S_PEND:   st_d = len_ok ? S_RCHK : S_DONE;
      S_RCHK:   st_d = (i_q == '0) ? S_DONE : S_RV;
      S_RV:     st_d = S_RQ;
      S_RQ:     st_d = S_RJ1;
      S_RJ1:    st_d = S_RJ2;
      S_RJ2:    st_d = S_RWR;
      S_RWR:    st_d = S_RCHK;
      S_CRD:    st_d = S_CJ;
      S_CJ: begin
        if (kk == '0) st_d = inmeet_q ? S_MEQ : S_RET;
        else st_d = S_CST;
      end
      S_CST:    st_d = S_CRD;
      S_MRA:    st_d = S_MRB;
      S_MRB:    st_d = S_MSW;
      S_MSW:    st_d = S_CRD;
      S_MEQ:    st_d = (u_q == w_q) ? S_RET : S_MRU;
      S_MRU:    st_d = S_MRV;
      S_MRV:    st_d = S_MCMP;
      S_MCMP:   st_d = (pu_q == par_rd) ? S_RET : S_MRU;
      S_QDM:    st_d = S_QDM2;
      S_QDM2: begin
        if (kind_e'(r_q.kind) == K_DIST || kx > tot) st_d = S_DONE;
        else st_d = S_CRD;
      end
      S_RET: begin
        priority if (kind_e'(r_q.kind) == K_PATH && phase_q == 2'd0) st_d = S_QDM;
        else if (kind_e'(r_q.kind) == K_DIST) st_d = S_QDM;
        else if (kind_e'(r_q.kind) == K_MED && phase_q != 2'd2) st_d = S_MRA;
        else st_d = S_DONE;
      end
      S_DONE:   st_d = S_IDLE;
      default:  st_d = S_IDLE;
    endcase
  end

  always_comb begin
    deg_we = 1'b0; deg_wa = '0; deg_wd = '0; nx_wd = '0; deg_ra = '0;
    wdeg_we = 1'b0; wdeg_wa = '0; wdeg_wd = '0; wdeg_ra = '0;
    wadj_we = 1'b0; wadj_wa = '0; wadj_wd = '0;
    peel_we = 1'b0; peel_wa = '0; peel_wd = 1'b0; peel_ra = '0;
    par_we = 1'b0; par_wa = '0; par_wd = '0; par_ra = '0;
    dep_we = 1'b0; dep_wa = '0; dep_wd = '0; dep_ra = '0;
    jmp_we = 1'b0; jmp_wa = '0; jmp_wd = '0; jmp_ra = '0;
    ord_we = 1'b0; ord_wa = '0; ord_wd = '0; ord_ra = '0;
    unique case (st_q)
      S_CLR: begin
        deg_we = 1'b1; deg_wa = clr_q;
      end
      S_LRA: deg_ra = AW'(r_q.node_a);
      S_LWA: begin
        deg_we = 1'b1; deg_wa = AW'(r_q.node_a);
        deg_wd = deg_rd + 1'b1; nx_wd = nx_rd ^ r_q.node_b;
      end
      S_LRB: deg_ra = AW'(r_q.node_b);
      S_LWB: begin
        deg_we = 1'b1; deg_wa = AW'(r_q.node_b);
        deg_wd = deg_rd + 1'b1; nx_wd = nx_rd ^ r_q.node_a;
      end
      S_BCP_RD: deg_ra = AW'(i_q);
      S_BCP_WR: begin
        wdeg_we = 1'b1; wdeg_wa = AW'(i_q);
        wdeg_wd = (i_q == NCW'(root_q)) ? '0 : signed'({1'b0, deg_rd});
        wadj_we = 1'b1; wadj_wa = AW'(i_q); wadj_wd = nx_rd;
        peel_we = 1'b1; peel_wa = AW'(i_q); peel_wd = 1'b0;
      end
      S_PRD: wdeg_ra = AW'(v_q);
      S_PCHK: begin
        wdeg_ra = AW'(wadj_rd);
        peel_ra = AW'(wadj_rd);
      end
      S_PDO: begin
        if (!peel_fail) begin
          wdeg_we = 1'b1; wdeg_wa = AW'(v_q); wdeg_wd = '0;
          peel_we = 1'b1; peel_wa = AW'(v_q); peel_wd = 1'b1;
          par_we = 1'b1; par_wa = AW'(v_q); par_wd = q_q;
          ord_we = 1'b1; ord_wa = AW'(len_q); ord_wd = NW'(v_q);
        end
      end
      S_PDO2: begin
        wdeg_we = 1'b1; wdeg_wa = AW'(q_q); wdeg_wd = tdeg_q - WDEG_ONE;
        wadj_we = 1'b1; wadj_wa = AW'(q_q); wadj_wd = tadj_q ^ NW'(v_q);
      end
      S_PEND: begin
        if (len_ok) begin
          par_we = 1'b1; par_wa = AW'(root_q); par_wd = root_q;
          jmp_we = 1'b1; jmp_wa = AW'(root_q); jmp_wd = root_q;
          dep_we = 1'b1; dep_wa = AW'(root_q); dep_wd = '0;
        end
      end
      S_RCHK: ord_ra = AW'(i_q - 1'b1);
      S_RV:   par_ra = AW'(ord_rd);
      S_RQ: begin
        jmp_ra = AW'(par_rd); dep_ra = AW'(par_rd);
      end
      S_RJ1: begin
        jmp_ra = AW'(jmp_rd); dep_ra = AW'(jmp_rd);
      end
      S_RJ2: dep_ra = AW'(jmp_rd);
      S_RWR: begin
        dep_we = 1'b1; dep_wa = AW'(v_q); dep_wd = dq_q + 1'b1;
        jmp_we = 1'b1; jmp_wa = AW'(v_q); jmp_wd = jump_ok ? j2_q : q_q;
      end
      S_CRD: begin
        dep_ra = AW'(u_q); jmp_ra = AW'(u_q); par_ra = AW'(u_q);
      end
      S_CJ:  dep_ra = AW'(jmp_rd);
      S_MRA: dep_ra = AW'(u_q);
      S_MRB: dep_ra = AW'(w_q);
      S_MRU: begin
        par_ra = AW'(u_q); jmp_ra = AW'(u_q);
      end
      S_MRV: begin
        par_ra = AW'(w_q); jmp_ra = AW'(w_q);
      end
      S_QDM: dep_ra = AW'(m_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_CLR;
      clr_q   <= '0;
      pend_q  <= 1'b0;
      built_q <= 1'b0;
      root_q  <= '0;
      len_q   <= '0;
      phase_q <= '0;
      clamp_q <= 1'b0;
      inmeet_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) built_q <= 1'b0;
      unique case (st_q)
        S_CLR: clr_q <= clr_q + 1'b1;
        S_IDLE: begin
          if (start_i) begin
            r_q     <= req_i;
            rsp_q   <= '{node_out: '0, distance: '0, status: ST_OK};
            phase_q <= '0;
            u_q     <= req_i.node_a;
            w_q     <= req_i.node_b;
            ck_q    <= req_i.steps;
            clamp_q <= 1'b1;
            inmeet_q <= 1'b0;
            i_q     <= '0;
            v_q     <= '0;
            unique case (kind_e'(req_i.kind))
              K_CLEAR: begin
                clr_q <= '0; pend_q <= 1'b1;
                root_q <= '0; built_q <= 1'b0; len_q <= '0;
              end
              K_LOAD: begin
                if (a_bad || (!req_i.is_root && b_bad)) begin
                  rsp_q.status <= ST_RANGE;
                end else begin
                  built_q <= 1'b0;
                  if (req_i.is_root) root_q <= req_i.node_a;
                end
              end
              K_BUILD: begin
                built_q <= 1'b0;
                len_q   <= '0;
                if (n_i == '0 || NCW'(root_q) >= n_i) rsp_q.status <= ST_NOTBUILT;
              end
              K_JUMP: begin
                if (!built_q) rsp_q.status <= ST_NOTBUILT;
                else if (a_bad) rsp_q.status <= ST_RANGE;
              end
              K_MED: begin
                if (!built_q) rsp_q.status <= ST_NOTBUILT;
                else if (a_bad || b_bad || c_bad) rsp_q.status <= ST_RANGE;
              end
              K_LCA, K_PATH, K_DIST: begin
                if (!built_q) rsp_q.status <= ST_NOTBUILT;
                else if (a_bad || b_bad) rsp_q.status <= ST_RANGE;
              end
            endcase
          end
        end
        S_BCP_WR: begin
          i_q <= NCW'(i_q + 1'b1);
          if (NCW'(i_q + 1'b1) == n_i) begin
            i_q <= '0;
            v_q <= '0;
          end
        end
        S_PCHK: begin
          q_q <= wadj_rd;
          if (wdeg_rd != WDEG_ONE) begin
            i_q <= NCW'(i_q + 1'b1);
            v_q <= NCW'(i_q + 1'b1);
          end
        end
        S_PDO: begin
          tdeg_q <= wdeg_rd;
          tadj_q <= wadj_rd;
          if (peel_fail) begin
            rsp_q.status <= ST_NOTBUILT;
            len_q <= '0;
          end else begin
            len_q <= NCW'(len_q + 1'b1);
          end
        end
        S_PDO2: v_q <= NCW'(q_q);
        S_PEND: begin
          i_q <= len_q;
          if (!len_ok) begin
            rsp_q.status <= ST_NOTBUILT;
            len_q <= '0;
          end
        end
        S_RCHK: if (i_q == '0) built_q <= 1'b1;
        S_RV:   v_q <= NCW'(ord_rd);
        S_RQ:   q_q <= par_rd;
        S_RJ1: begin
          dq_q <= dep_rd;
        end
        S_RJ2: begin
          j2_q  <= jmp_rd;
          dj1_q <= dep_rd;
        end
        S_RWR:  i_q <= NCW'(i_q - 1'b1);
        S_CJ: begin
          ck_q    <= kk;
          clamp_q <= 1'b0;
          dv_q    <= dep_rd;
          jv_q    <= jmp_rd;
          pv_q    <= par_rd;
        end
        S_CST: begin
          if (cdist != '0 && cdist <= ck_q) begin
            u_q  <= jv_q;
            ck_q <= ck_q - cdist;
          end else begin
            u_q  <= pv_q;
            ck_q <= ck_q - 1'b1;
          end
        end
        S_MRB: da_q <= dep_rd;
        S_MSW: begin
          db_q     <= dep_rd;
          clamp_q  <= 1'b1;
          inmeet_q <= 1'b1;
          if (da_q < dep_rd) begin
            u_q  <= w_q;
            w_q  <= u_q;
            ck_q <= dep_rd - da_q;
          end else begin
            ck_q <= da_q - dep_rd;
          end
        end
        S_MEQ: if (u_q == w_q) m_q <= u_q;
        S_MRV: begin
          pu_q <= par_rd;
          ju_q <= jmp_rd;
        end
        S_MCMP: begin
          if (pu_q == par_rd) begin
            m_q <= pu_q;
          end else if (ju_q != jmp_rd) begin
            u_q <= ju_q;
            w_q <= jmp_rd;
          end else begin
            u_q <= pu_q;
            w_q <= par_rd;
          end
        end
        S_QDM2: begin
          if (kind_e'(r_q.kind) == K_DIST) begin
            rsp_q.distance <= da_q + db_q - {dep_rd[NW-2:0], 1'b0};
          end else if (kx > tot) begin
            rsp_q.status <= ST_PASTEND;
          end else begin
            phase_q  <= 2'd1;
            clamp_q  <= 1'b1;
            inmeet_q <= 1'b0;
            if (NCW'(up) >= kx) begin
              u_q  <= r_q.node_a;
              ck_q <= r_q.steps;
            end else begin
              u_q  <= r_q.node_b;
              ck_q <= NW'(tot - kx);
            end
          end
        end
        S_RET: begin
          unique case (kind_e'(r_q.kind))
            K_JUMP: rsp_q.node_out <= u_q;
            K_LCA:  rsp_q.node_out <= m_q;
            K_PATH: if (phase_q != 2'd0) rsp_q.node_out <= u_q;
            K_MED: begin
              unique case (phase_q)
                2'd0: begin
                  acc_q <= m_q; u_q <= r_q.node_a; w_q <= r_q.node_c;
                  phase_q <= 2'd1;
                end
                2'd1: begin
                  acc_q <= acc_q ^ m_q; u_q <= r_q.node_b; w_q <= r_q.node_c;
                  phase_q <= 2'd2;
                end
                default: rsp_q.node_out <= acc_q ^ m_q;
              endcase
            end
            default: ;
          endcase
        end
        S_DONE: pend_q <= 1'b0;
        default: ;
      endcase
    end
  end

  assign idle_o = st_q == S_IDLE;
  assign done_o = st_q == S_DONE;
  assign rsp_o  = rsp_q;

endmodule

// File: rtl/tree_jump_pointer_ancestor_engine_unit.sv
// Rooted-tree engine: load parent edges one word at a time, build once, then ask for k-th
// ancestor, lowest common ancestor, k-th node on a path, distance or median of three. Every
// operation runs on a small sequencer over tables with registered reads, so one word is taken
// at a time and ready stays low until its result word is taken. After reset and after a clear
// word the degree and neighbour-xor tables are swept over all MAX_NODES entries. An edge load
// reads and updates the entries of both endpoints; a build copies the tables, peels leaves
// toward the root, then writes depths and jump pointers; a query walks jump or parent steps,
// with a logarithmic step count, on registered read data.
module tree_jump_pointer_ancestor_engine_unit import tjp_pkg::*; #(
  parameter int MAX_NODES = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           node_count_we_i,
  input  logic [NCW-1:0] node_count_i,
  tjp_req_if.sink        req_i,
  tjp_rsp_if.source      rsp_o
);

  logic [NCW-1:0] node_count_q, n;
  logic           out_valid_q, core_idle, core_done, accept;
  rsp_t           out_q, core_rsp;
  req_t           req;

  assign n = (32'(node_count_q) > MAX_NODES) ? NCW'(MAX_NODES) : node_count_q;

  assign req = '{kind: req_i.kind, node_a: req_i.node_a, node_b: req_i.node_b,
                 node_c: req_i.node_c, is_root: req_i.is_root, steps: req_i.steps};

  assign req_i.ready = core_idle && !out_valid_q;
  assign accept      = req_i.valid && req_i.ready;

  tjp_core #(.MAX_NODES(MAX_NODES)) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .req_i    (req),
    .n_i      (n),
    .cfg_we_i (node_count_we_i),
    .idle_o   (core_idle),
    .done_o   (core_done),
    .rsp_o    (core_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
      out_valid_q  <= 1'b0;
    end else begin
      if (node_count_we_i) node_count_q <= node_count_i;
      if (core_done) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_done) out_q <= core_rsp;
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.node_out = out_q.node_out;
  assign rsp_o.distance = out_q.distance;
  assign rsp_o.status   = out_q.status;

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status != ST_OK |-> out_q.node_out == '0 && out_q.distance == '0)
    else $error("error word carries a nonzero payload");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !req_i.ready)
    else $error("ready high right after a word was taken");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_done |-> !out_valid_q)
    else $error("result finished while the output word was still held");
`endif

endmodule

// File: sim/tb_tree_jump_pointer_ancestor_engine_unit.sv
`timescale 1ns / 1ps

module tb_tree_jump_pointer_ancestor_engine_unit;
  import tjp_pkg::*;

  class tree_answers;
    int unsigned par[1024];
    int unsigned dep[1024];
    int unsigned jmp[1024];
    int unsigned deg[1024];
    int unsigned nxor[1024];
    int unsigned order[1023];
    int unsigned order_len;
    int unsigned root;
    bit built;
    int unsigned count;
    rsp_t pending_answers[$];
    int mismatches;

    function void reset_state();
      for (int i = 0; i < 1024; i++) begin
        par[i] = 0; dep[i] = 0; jmp[i] = 0; deg[i] = 0; nxor[i] = 0;
      end
      order_len = 0;
      root = 0;
      built = 0;
      count = 1024;
      mismatches = 0;
    endfunction

    function void set_count(int unsigned v);
      count = v & 11'h7ff;
      built = 0;
    endfunction

    function int unsigned active();
      return (count > 1024) ? 1024 : count;
    endfunction

    function bit build_tree();
      int unsigned n;
      int unsigned len;
      int unsigned v;
      int unsigned q;
      int unsigned j1;
      int unsigned j2;
      int wdeg[1024];
      int unsigned wadj[1024];
      bit peeled[1024];
      n = active();
      len = 0;
      if (n == 0 || root >= n) return 0;
      for (int i = 0; i < n; i++) begin
        wdeg[i] = deg[i]; wadj[i] = nxor[i]; peeled[i] = 0;
        par[i] = 0; dep[i] = 0; jmp[i] = 0;
      end
      wdeg[root] = 0;
      for (int i = 0; i < n; i++) begin
        v = i;
        while (wdeg[v] == 1) begin
          q = wadj[v];
          if (q >= n || q == v || peeled[q] || len >= 1023) return 0;
          order[len] = v;
          len++;
          peeled[v] = 1;
          par[v] = q;
          wdeg[v] = 0;
          wdeg[q] -= 1;
          wadj[q] ^= v;
          v = q;
        end
      end
      if (len != n - 1) return 0;
      order_len = len;
      par[root] = root;
      jmp[root] = root;
      dep[root] = 0;
      for (int i = len; i > 0; i--) begin
        v = order[i-1];
        q = par[v];
        j1 = jmp[q];
        j2 = jmp[j1];
        dep[v] = dep[q] + 1;
        jmp[v] = (dep[q] + dep[j2] == 2 * dep[j1]) ? j2 : q;
      end
      return 1;
    endfunction

    function int unsigned climb(int unsigned v, int unsigned k);
      int unsigned d;
      if (k > dep[v]) k = dep[v];
      while (k != 0) begin
        d = dep[v] - dep[jmp[v]];
        if (d != 0 && d <= k) begin
          v = jmp[v];
          k -= d;
        end else begin
          v = par[v];
          k -= 1;
        end
      end
      return v;
    endfunction

    function int unsigned meet(int unsigned u, int unsigned v);
      int unsigned t;
      if (dep[u] < dep[v]) begin
        t = u; u = v; v = t;
      end
      u = climb(u, dep[u] - dep[v]);
      if (u == v) return u;
      while (par[u] != par[v]) begin
        if (jmp[u] != jmp[v]) begin
          u = jmp[u]; v = jmp[v];
        end else begin
          u = par[u]; v = par[v];
        end
      end
      return par[u];
    endfunction

    function rsp_t answer_word(req_t w);
      rsp_t r;
      int unsigned n;
      int unsigned a;
      int unsigned b;
      int unsigned c;
      int unsigned k;
      int unsigned m;
      int unsigned up;
      int unsigned total;
      int unsigned node;
      int unsigned span;
      status_e st;
      n = active();
      a = w.node_a; b = w.node_b; c = w.node_c; k = w.steps;
      node = 0; span = 0; st = ST_OK;
      case (kind_e'(w.kind))
        K_CLEAR: begin
          for (int i = 0; i < 1024; i++) begin
            deg[i] = 0; nxor[i] = 0;
          end
          order_len = 0; root = 0; built = 0;
        end
        K_LOAD: begin
          if (a >= n || (!w.is_root && b >= n)) begin
            st = ST_RANGE;
          end else begin
            if (w.is_root) begin
              root = a;
            end else begin
              deg[a] = (deg[a] + 1) & 10'h3ff;
              deg[b] = (deg[b] + 1) & 10'h3ff;
              nxor[a] ^= b;
              nxor[b] ^= a;
            end
            built = 0;
          end
        end
        K_BUILD: begin
          if (build_tree()) begin
            built = 1;
          end else begin
            built = 0; order_len = 0; st = ST_NOTBUILT;
          end
        end
        default: begin
          if (!built) begin
            st = ST_NOTBUILT;
          end else if (a >= n || (w.kind != K_JUMP && b >= n) || (w.kind == K_MED && c >= n)) begin
            st = ST_RANGE;
          end else begin
            case (kind_e'(w.kind))
              K_JUMP: node = climb(a, k);
              K_LCA: node = meet(a, b);
              K_PATH: begin
                m = meet(a, b);
                up = dep[a] - dep[m];
                total = up + dep[b] - dep[m];
                if (k > total) st = ST_PASTEND;
                else if (up >= k) node = climb(a, k);
                else node = climb(b, total - k);
              end
              K_DIST: begin
                m = meet(a, b);
                span = dep[a] + dep[b] - 2 * dep[m];
              end
              default: node = meet(a, b) ^ meet(a, c) ^ meet(b, c);
            endcase
          end
        end
      endcase
      r.node_out = node[9:0];
      r.distance = span[9:0];
      r.status = st;
      return r;
    endfunction

    function void note_word(req_t w);
      pending_answers.push_back(answer_word(w));
    endfunction

    function void check_word(rsp_t got);
      rsp_t exp;
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: node %0d dist %0d status %0d",
                   got.node_out, got.distance, got.status);
        return;
      end
      exp = pending_answers.pop_front();
      if (got.node_out !== exp.node_out || got.distance !== exp.distance ||
          got.status !== exp.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp node %0d dist %0d status %0d, got node %0d dist %0d status %0d",
                   exp.node_out, exp.distance, exp.status,
                   got.node_out, got.distance, got.status);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic node_count_we_i;
  logic [NCW-1:0] node_count_i;
  tjp_req_if req_if();
  tjp_rsp_if rsp_if();

  tree_answers answers;
  bit idle_on;
  int hold_cycles;
  int words_sent;

  tree_jump_pointer_ancestor_engine_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .node_count_we_i(node_count_we_i),
    .node_count_i   (node_count_i),
    .req_i          (req_if),
    .rsp_o          (rsp_if)
  );

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #60_000_000;
    $display("[tree_jump_pointer_ancestor_engine_unit] ERROR");
    $finish;
  end

  initial begin
    rsp_if.ready = 0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        rsp_if.ready <= 0;
        hold_cycles--;
      end else begin
        rsp_if.ready <= !(idle_on && $urandom_range(99) < 32);
      end
    end
  end

  always @(posedge clk_i) begin
    rsp_t got;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.node_out = rsp_if.node_out;
      got.distance = rsp_if.distance;
      got.status = status_e'(rsp_if.status);
      answers.check_word(got);
    end
  end

  task automatic send_word(kind_e kind, int a, int b, int c, bit r, int s);
    req_t w;
    w.kind = kind; w.node_a = NW'(a); w.node_b = NW'(b); w.node_c = NW'(c);
    w.is_root = r; w.steps = NW'(s);
    if (idle_on) begin
      while ($urandom_range(99) < 32) begin
        req_if.valid <= 0;
        @(negedge clk_i);
      end
    end
    req_if.valid <= 1;
    req_if.kind <= w.kind;
    req_if.node_a <= w.node_a;
    req_if.node_b <= w.node_b;
    req_if.node_c <= w.node_c;
    req_if.is_root <= w.is_root;
    req_if.steps <= w.steps;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    answers.note_word(w);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    req_if.valid <= 0;
    while (answers.pending_answers.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_count(int v);
    drain();
    node_count_we_i <= 1;
    node_count_i <= NCW'(v);
    @(negedge clk_i);
    node_count_we_i <= 0;
    answers.set_count(v);
  endtask

  task automatic load_tree(int n, int flaw);
    int perm[1024];
    int t;
    int j;
    int p;
    for (int i = 0; i < n; i++) perm[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = perm[i]; perm[i] = perm[j]; perm[j] = t;
    end
    if (flaw != 1) send_word(K_LOAD, perm[0], $urandom_range(1023), 0, 1, $urandom_range(1023));
    for (int i = 1; i < n; i++) begin
      p = ($urandom_range(2) == 0) ? perm[i-1] : perm[$urandom_range(i - 1)];
      if (flaw == 2 && i == n - 1) continue;
      if ($urandom_range(1)) send_word(K_LOAD, perm[i], p, $urandom_range(1023), 0,
                                       $urandom_range(1023));
      else send_word(K_LOAD, p, perm[i], $urandom_range(1023), 0, $urandom_range(1023));
    end
    if (flaw == 3) begin
      j = $urandom_range(n - 1);
      send_word(K_LOAD, j, j, 0, 0, 0);
    end
    if (flaw == 4) send_word(K_LOAD, $urandom_range(n - 1), $urandom_range(n - 1), 0, 0, 0);
  endtask

  function automatic int pick_node(int n);
    if (n == 0 || $urandom_range(99) < 8) return $urandom_range(1023);
    return $urandom_range(n - 1);
  endfunction

  task automatic send_query(int n);
    int s;
    s = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(2 * n + 2);
    send_word(kind_e'($urandom_range(K_JUMP, K_MED)), pick_node(n), pick_node(n),
              pick_node(n), $urandom_range(1), s);
  endtask

  task automatic send_noise();
    int k;
    k = $urandom_range(7);
    if (k == K_CLEAR && $urandom_range(9) != 0) k = K_BUILD;
    send_word(kind_e'(k), $urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
              $urandom_range(1), $urandom_range(1023));
  endtask

  initial begin
    int n;
    int phase;
    int cfg_val;
    answers = new();
    answers.reset_state();
    idle_on = 1;
    hold_cycles = 0;
    words_sent = 0;
    rst_ni = 0;
    node_count_we_i = 0;
    node_count_i = NODE_COUNT_RST;
    req_if.valid = 0;
    req_if.kind = K_CLEAR;
    req_if.node_a = 0;
    req_if.node_b = 0;
    req_if.node_c = 0;
    req_if.is_root = 0;
    req_if.steps = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1;

    write_count(4);
    send_word(K_JUMP, 0, 0, 0, 0, 0);
    send_word(K_BUILD, 0, 0, 0, 0, 0);
    send_word(K_LOAD, 1023, 0, 0, 1, 0);
    send_word(K_LOAD, 1, 1023, 0, 0, 0);
    send_word(K_LOAD, 2, 0, 0, 1, 1023);
    send_word(K_LOAD, 0, 2, 0, 0, 0);
    send_word(K_LOAD, 1, 0, 0, 0, 0);
    send_word(K_LOAD, 3, 1, 0, 0, 0);
    send_word(K_BUILD, 0, 0, 0, 0, 0);
    send_word(K_JUMP, 3, 0, 0, 0, 1023);
    send_word(K_JUMP, 3, 0, 0, 0, 0);
    send_word(K_JUMP, 3, 1023, 0, 0, 2);
    send_word(K_LCA, 3, 2, 0, 0, 0);
    send_word(K_PATH, 3, 2, 0, 0, 2);
    send_word(K_PATH, 3, 2, 0, 0, 1023);
    send_word(K_DIST, 3, 2, 0, 0, 0);
    send_word(K_MED, 3, 2, 1, 0, 0);
    send_word(K_MED, 3, 2, 1023, 0, 0);
    send_word(K_LCA, 1023, 0, 0, 0, 0);
    send_word(K_CLEAR, 0, 0, 0, 0, 0);
    send_word(K_BUILD, 0, 0, 0, 0, 0);

    phase = 0;
    while (words_sent < 1950) begin
      idle_on = !(phase >= 4 && phase < 9);
      case (phase % 17)
        3: cfg_val = 1;
        6: cfg_val = 0;
        9: cfg_val = 2047;
        12: cfg_val = 2;
        15: cfg_val = $urandom_range(60, 200);
        default: cfg_val = $urandom_range(2, 24);
      endcase
      if (phase == 20) cfg_val = 1024;
      write_count(cfg_val);
      n = (cfg_val > 1024) ? 1024 : cfg_val;
      if (phase == 2) hold_cycles = 600;
      if ($urandom_range(4) != 0 || n >= 1024) send_word(K_CLEAR, 0, 0, 0, 0, 0);
      if (n > 0) load_tree(n, ($urandom_range(9) < 7) ? 0 : $urandom_range(1, 4));
      if ($urandom_range(5) == 0) send_noise();
      send_word(K_BUILD, $urandom_range(1023), 0, 0, 0, 0);
      repeat ($urandom_range(20, 45)) begin
        if ($urandom_range(99) < 5) send_noise();
        else send_query(n);
      end
      phase++;
    end

    req_if.valid <= 0;
    while (answers.pending_answers.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (answers.mismatches == 0) begin
      $display("[tree_jump_pointer_ancestor_engine_unit] OK");
    end else begin
      $display("[tree_jump_pointer_ancestor_engine_unit] ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/tjp_pkg.sv
rtl/tjp_req_if.sv
rtl/tjp_rsp_if.sv
rtl/tjp_core.sv
rtl/tree_jump_pointer_ancestor_engine_unit.sv
sim/tb_tree_jump_pointer_ancestor_engine_unit.sv
